>>> hw/rtl/afcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afcp_pkg
// Shared constants, result type and hex digit decode for the ASCII frame
// checksum parser.
// ----------------------------------------------------------------------------
package afcp_pkg;

  localparam int unsigned BUFFER_SIZE = 16;

  localparam int unsigned CountW = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 3;

  localparam logic [ByteW-1:0] START_MARK = 8'h23;
  localparam logic [ByteW-1:0] END_MARK   = 8'h24;

  localparam logic [StatW-1:0] ST_NONE     = 3'd0;
  localparam logic [StatW-1:0] ST_OK       = 3'd1;
  localparam logic [StatW-1:0] ST_RESTART  = 3'd2;
  localparam logic [StatW-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [StatW-1:0] ST_BADLEN   = 3'd4;
  localparam logic [StatW-1:0] ST_BADSUM   = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  localparam logic [CountW-1:0] MIN_LENGTH_RST = 7'd5;
  localparam logic [CountW-1:0] MAX_LENGTH_RST = 7'd12;
  localparam logic [CountW-1:0] BUF_SIZE_C     = CountW'(BUFFER_SIZE);

  typedef struct packed {
    logic [CountW-1:0] frame_length;
    logic [StatW-1:0]  status;
  } res_t;

  // Decimal digits give their value; anything else decodes as c - 'A' + 10.
  function automatic logic [ByteW-1:0] hex_nibble(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] val;
    if (c >= 8'h30 && c <= 8'h39) begin
      val = c - 8'h30;
    end else begin
      val = c - 8'h37;
    end
    return val;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/afcp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afcp_core
// Frame state, length bounds and checksum check; forms the result of each
// accepted item combinationally from the stored frame state.
// ----------------------------------------------------------------------------
module afcp_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_index,
  input  wire logic [6:0]                   cfg_wdata,
  output afcp_pkg::res_t                    res
);
  import afcp_pkg::*;

  logic              in_frame_r, in_frame_nxt;
  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic [ByteW-1:0]  running_sum_r, running_sum_nxt;
  logic [ByteW-1:0]  prev_r, prev_nxt;
  logic [ByteW-1:0]  prev2_r, prev2_nxt;
  logic [CountW-1:0] min_length_r, max_length_r;

  logic [CountW-1:0] count_inc;
  logic [ByteW-1:0]  body_sum;
  logic [ByteW-1:0]  nib_hi;
  logic [ByteW-1:0]  nib_lo;
  logic [ByteW-1:0]  check_val;

  assign count_inc = byte_count_r + 7'd1;
  assign body_sum  = running_sum_r - prev_r - prev2_r;
  assign nib_hi    = hex_nibble(prev2_r);
  assign nib_lo    = hex_nibble(prev_r);
  assign check_val = {nib_hi[3:0], 4'b0000} + nib_lo;

  always_comb begin
    in_frame_nxt    = in_frame_r;
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    prev_nxt        = prev_r;
    prev2_nxt       = prev2_r;
    res             = '0;
    if (accept) begin
      if (data_byte == START_MARK) begin
        in_frame_nxt    = 1'b1;
        byte_count_nxt  = 7'd1;
        running_sum_nxt = START_MARK;
        prev_nxt        = START_MARK;
        prev2_nxt       = '0;
        if (in_frame_r) begin
          res.status = ST_RESTART;
        end
      end else if (in_frame_r) begin
        if (data_byte == END_MARK) begin
          in_frame_nxt     = 1'b0;
          res.frame_length = byte_count_r;
          if (byte_count_r < min_length_r || byte_count_r > max_length_r) begin
            res.status = ST_BADLEN;
          end else if (byte_count_r < 7'd2) begin
            res.status = ST_BADSUM;
          end else if (body_sum == check_val) begin
            res.status = ST_OK;
          end else begin
            res.status = ST_BADSUM;
          end
        end else begin
          running_sum_nxt = running_sum_r + data_byte;
          prev2_nxt       = prev_r;
          prev_nxt        = data_byte;
          byte_count_nxt  = count_inc;
          if (count_inc >= BUF_SIZE_C) begin
            in_frame_nxt = 1'b0;
            res.status   = ST_OVERFLOW;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      byte_count_r  <= '0;
      running_sum_r <= '0;
      prev_r        <= '0;
      prev2_r       <= '0;
    end else begin
      in_frame_r    <= in_frame_nxt;
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      prev_r        <= prev_nxt;
      prev2_r       <= prev2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MIN_LENGTH_RST;
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_LENGTH: min_length_r <= cfg_wdata;
        CFG_MAX_LENGTH: max_length_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // An open frame always holds at least the start byte and never a full buffer.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (byte_count_r >= 7'd1 && byte_count_r < BUF_SIZE_C))
    else $error("frame byte count out of range");

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && data_byte == START_MARK) |=>
      (in_frame_r && byte_count_r == 7'd1 && running_sum_r == START_MARK))
    else $error("start marker did not open a fresh frame");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_frame_r && data_byte == START_MARK) |-> res.status == ST_RESTART)
    else $error("start marker inside a frame not reported as restart");

  a_length_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status == ST_NONE || res.status == ST_RESTART || res.status == ST_OVERFLOW)
      |-> res.frame_length == 7'd0)
    else $error("frame length given without an end marker");

endmodule
`default_nettype wire

>>> hw/rtl/afcp_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afcp_out_reg
// Result register with valid flag; frees itself in the cycle its item is
// taken so that a new item can be accepted every cycle while results are taken.
// ----------------------------------------------------------------------------
module afcp_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire afcp_pkg::res_t res,
  input  wire logic           out_tready,
  output logic                out_tvalid,
  output afcp_pkg::res_t      out_res,
  output logic                can_load
);
  import afcp_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  assign can_load = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

>>> hw/rtl/ascii_frame_checksum_parser_unit.sv
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; in_tready is low only while a result waits
// in the output register and out_tready is low.
// Reset (rst_n low, synchronous): no frame open, output empty, min_length 5
// and max_length 12.
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_frame_checksum_parser_unit
// Checks '#'...'$' framed byte streams for length and hex checksum and gives
// one status item for every received byte.
// ----------------------------------------------------------------------------
module ascii_frame_checksum_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] status, [9:3] frame_length, rest zero
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata
);
  import afcp_pkg::*;

  logic in_accept;
  res_t res;
  res_t out_res;

  assign in_accept = in_tvalid && in_tready;

  afcp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  afcp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .can_load   (in_tready)
  );

  assign out_tdata = {6'b000000, out_res.frame_length, out_res.status};

endmodule
`default_nettype wire
